### hw/rtl/adpdc_pkg.sv
// ----------------------------------------------------------------------------
// adpdc_pkg
// Types, constants and the divider step shared by the clock setup pipeline.
// ----------------------------------------------------------------------------
package adpdc_pkg;

	// operand widths
	localparam int unsigned RATE_W = 19;
	localparam int unsigned BITS_W = 6;
	localparam int unsigned BCLK_W = 26;
	localparam int unsigned NUM_W  = 27;
	localparam int unsigned QUO_W  = 12;
	localparam int unsigned TRY_W  = NUM_W + QUO_W;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BCLK     = 2'd1;
	localparam logic [1:0] ST_RATE24   = 2'd2;
	localparam logic [1:0] ST_WORD_LEN = 2'd3;

	// word codes
	localparam logic [1:0] WC_16 = 2'd0;
	localparam logic [1:0] WC_24 = 2'd2;
	localparam logic [1:0] WC_32 = 2'd3;
	localparam logic [5:0] IFACE_BASE = 6'h30;

	// clock constants
	localparam logic [NUM_W-1:0]  PLL_441_HZ   = 27'd90316800;
	localparam logic [NUM_W-1:0]  PLL_48_HZ    = 27'd98304000;
	localparam logic [NUM_W-1:0]  IDAC_NUM_HZ  = 27'd49152000;
	localparam logic [NUM_W-1:0]  OSR_BASE_HZ  = 27'd384000;
	localparam logic [BCLK_W-1:0] BCLK_MIN_HZ  = 26'd1000000;
	localparam logic [BCLK_W-1:0] BCLK_MAX_HZ  = 26'd50000000;
	localparam logic [BCLK_W-1:0] BCLK_P3_HZ   = 26'd1536000;
	localparam logic [BCLK_W-1:0] BCLK_P2_HZ   = 26'd12288000;
	localparam logic [15:0]       IDAC_FIXED   = 16'd1024;

	// divide by three as multiply and shift, exact below 2**26
	localparam int unsigned       RECIP3_SH = 28;
	localparam logic [26:0]       RECIP3    = 27'd89478486;

	// one division in flight: partial remainder, divisor and quotient so far
	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [NUM_W-1:0] den;
		logic [QUO_W-1:0] quo;
	} lane_t;

	// what travels down the cell row with each transfer
	typedef struct packed {
		logic [1:0] status;
		logic [1:0] p_field;
		logic [6:0] dsp_div;
		logic [1:0] speed;
		logic [1:0] code;
		logic       mclk;
		logic       fam441;
		logic       idac_fix;
		lane_t      j_lane;
		lane_t      osr_lane;
		lane_t      idac_lane;
	} item_t;

	// one restoring division step at a fixed bit position
	function automatic lane_t div_step(lane_t l, int unsigned sh);
		logic [TRY_W-1:0] trial;
		logic             ge;
		lane_t            r;
		trial = {{QUO_W{1'b0}}, l.den} << sh;
		ge    = {{QUO_W{1'b0}}, l.rem} >= trial;
		r     = l;
		r.quo = {l.quo[QUO_W-2:0], ge};
		if (ge) begin
			r.rem = l.rem - trial[NUM_W-1:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/audio_dac_pll_divider_calc.sv
// ----------------------------------------------------------------------------
// audio_dac_pll_divider_calc
// PLL and clock divider setup for an audio DAC clocked from the bit clock.
// ----------------------------------------------------------------------------
// Accepts one request per cycle while the output side does not stall. Each
// request passes two front stages for the bit clock product and the divide
// by three, then the row of twelve divider cells, each resolving one
// quotient bit of the PLL multiplier, oversampling and DSP cycle divisions,
// and then the output register. A stall on the output holds the whole
// pipeline.
module audio_dac_pll_divider_calc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// sample_rate[18:0], bits_per_sample[24:19]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], pll_p_field[3:2], pll_j_field[11:4], pll_r_field[15:12],
	// dsp_div_field[22:16], dac_div_field[29:23], charge_pump_div_field[36:30],
	// oversampling_div_field[43:37], dsp_cycles_per_sample[59:44],
	// speed_mode[61:60], word_format_code[67:62], mclk_multiple_384[68]
	output logic [71:0] m_tdata
);

	localparam int unsigned NCELL = adpdc_pkg::QUO_W;

	logic                   advance;
	logic                   valid_c [NCELL+1];
	adpdc_pkg::item_t       item_c  [NCELL+1];
	logic                   m_tvalid_q;
	logic [71:0]            m_tdata_q;
	logic [71:0]            data_d;
	adpdc_pkg::item_t       fin;
	logic                   ok;

	// pipeline moves whenever the output register is free or draining
	assign advance  = !m_tvalid_q || m_tready;
	assign s_tready = advance;

	adpdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (s_tvalid),
		.rate      (s_tdata[18:0]),
		.bits      (s_tdata[24:19]),
		.out_valid (valid_c[0]),
		.out_item  (item_c[0])
	);

	// divider cell row, most significant quotient bit first
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		adpdc_div_cell #(
			.SHIFT (NCELL - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.in_valid  (valid_c[i]),
			.in_item   (item_c[i]),
			.out_valid (valid_c[i+1]),
			.out_item  (item_c[i+1])
		);
	end

	// result assembly, error results keep only the status and the master clock select
	assign fin = item_c[NCELL];
	assign ok  = fin.status == adpdc_pkg::ST_OK;

	always_comb begin
		data_d        = '0;
		data_d[1:0]   = fin.status;
		data_d[68]    = fin.mclk;
		if (ok) begin
			data_d[3:2]   = fin.p_field;
			data_d[11:4]  = fin.j_lane.quo[7:0];
			data_d[15:12] = 4'd1;
			data_d[22:16] = fin.dsp_div;
			data_d[29:23] = 7'd15;
			data_d[36:30] = 7'd3;
			data_d[43:37] = fin.fam441 ? 7'd7 : (fin.osr_lane.quo[6:0] - 7'd1);
			data_d[59:44] = fin.idac_fix ? adpdc_pkg::IDAC_FIXED
				: {4'd0, fin.idac_lane.quo};
			data_d[61:60] = fin.speed;
			data_d[67:62] = adpdc_pkg::IFACE_BASE | {4'd0, fin.code};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= valid_c[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= data_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### hw/rtl/adpdc_front.sv
// ----------------------------------------------------------------------------
// adpdc_front
// Bit clock, checks, PLL input divider and divider operands in two stages.
// ----------------------------------------------------------------------------
module adpdc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  logic                             in_valid,
	input  logic [adpdc_pkg::RATE_W-1:0]     rate,
	input  logic [adpdc_pkg::BITS_W-1:0]     bits,
	output logic                             out_valid,
	output adpdc_pkg::item_t                 out_item
);

	logic                         valid_s1;
	logic [adpdc_pkg::RATE_W-1:0] rate_s1;
	logic [adpdc_pkg::BITS_W-1:0] bits_s1;
	logic [adpdc_pkg::BCLK_W-1:0] bclk_s1;
	logic [adpdc_pkg::BCLK_W-1:0] prod;
	logic [adpdc_pkg::BCLK_W-1:0] bclk_d;

	logic                         valid_s2;
	adpdc_pkg::item_t             item_s2;
	adpdc_pkg::item_t             item_d;

	logic                         b16, b24, b32, fam;
	logic [1:0]                   p_sel;
	logic [52:0]                  third_prod;
	logic [adpdc_pkg::BCLK_W-1:0] q;
	logic [adpdc_pkg::NUM_W-1:0]  rate_x;

	// bit clock is rate times bits times two
	assign prod   = {7'd0, rate} * {20'd0, bits};
	assign bclk_d = {prod[adpdc_pkg::BCLK_W-2:0], 1'b0};

	// first stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rate_s1 <= rate;
			bits_s1 <= bits;
			bclk_s1 <= bclk_d;
		end
	end

	// bit clock over three
	assign third_prod = {27'd0, bclk_s1} * {26'd0, adpdc_pkg::RECIP3};
	assign rate_x     = {8'd0, rate_s1};

	// checks, word code, P choice, DSP divider, speed mode and divider operands
	always_comb begin
		b16 = bits_s1 == 6'd16;
		b24 = bits_s1 == 6'd24;
		b32 = bits_s1 == 6'd32;
		fam = rate_s1 == 19'd11025 || rate_s1 == 19'd22050 || rate_s1 == 19'd44100;

		item_d = '0;
		item_d.mclk = b24;
		item_d.code = b24 ? adpdc_pkg::WC_24 : (b32 ? adpdc_pkg::WC_32 : adpdc_pkg::WC_16);

		if (!(b16 || b24 || b32)) begin
			item_d.status = adpdc_pkg::ST_WORD_LEN;
		end else if (bclk_s1 < adpdc_pkg::BCLK_MIN_HZ || bclk_s1 > adpdc_pkg::BCLK_MAX_HZ) begin
			item_d.status = adpdc_pkg::ST_BCLK;
		end else if ((rate_s1 == 19'd44100 || rate_s1 == 19'd48000) && b24) begin
			item_d.status = adpdc_pkg::ST_RATE24;
		end else begin
			item_d.status = adpdc_pkg::ST_OK;
		end

		if (fam) begin
			p_sel = 2'd0;
		end else if (b24 && bclk_s1 > adpdc_pkg::BCLK_P3_HZ) begin
			p_sel = 2'd2;
		end else if (bclk_s1 > adpdc_pkg::BCLK_P2_HZ) begin
			p_sel = 2'd1;
		end else begin
			p_sel = 2'd0;
		end

		case (p_sel)
			2'd2:    q = {1'b0, third_prod[52:adpdc_pkg::RECIP3_SH]};
			2'd1:    q = {1'b0, bclk_s1[adpdc_pkg::BCLK_W-1:1]};
			default: q = bclk_s1;
		endcase

		item_d.p_field = p_sel;
		item_d.fam441  = fam;
		item_d.idac_fix = fam || rate_s1 == 19'd16000 || rate_s1 == 19'd32000;

		if (fam) begin
			item_d.dsp_div = 7'd1;
		end else if (rate_s1 == 19'd16000) begin
			item_d.dsp_div = 7'd5;
		end else if (rate_s1 == 19'd32000) begin
			item_d.dsp_div = 7'd2;
		end else begin
			item_d.dsp_div = 7'd1;
		end

		if (rate_s1 <= 19'd48000) begin
			item_d.speed = 2'd0;
		end else if (rate_s1 <= 19'd96000) begin
			item_d.speed = 2'd1;
		end else if (rate_s1 <= 19'd192000) begin
			item_d.speed = 2'd2;
		end else begin
			item_d.speed = 2'd3;
		end

		item_d.j_lane.rem    = fam ? adpdc_pkg::PLL_441_HZ : adpdc_pkg::PLL_48_HZ;
		item_d.j_lane.den    = {q, 1'b0};
		item_d.j_lane.quo    = '0;
		item_d.osr_lane.rem  = adpdc_pkg::OSR_BASE_HZ;
		item_d.osr_lane.den  = rate_x;
		item_d.osr_lane.quo  = '0;
		item_d.idac_lane.rem = adpdc_pkg::IDAC_NUM_HZ;
		item_d.idac_lane.den = rate_x;
		item_d.idac_lane.quo = '0;
	end

	// second stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2 <= item_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

### hw/rtl/adpdc_div_cell.sv
// ----------------------------------------------------------------------------
// adpdc_div_cell
// One cell of the divider row: resolves one quotient bit in each lane.
// ----------------------------------------------------------------------------
module adpdc_div_cell #(
	parameter int unsigned SHIFT = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             in_valid,
	input  adpdc_pkg::item_t in_item,
	output logic             out_valid,
	output adpdc_pkg::item_t out_item
);

	logic             valid_q;
	adpdc_pkg::item_t item_q;
	adpdc_pkg::item_t item_d;

	// one restoring step per lane
	always_comb begin
		item_d           = in_item;
		item_d.j_lane    = adpdc_pkg::div_step(in_item.j_lane, SHIFT);
		item_d.osr_lane  = adpdc_pkg::div_step(in_item.osr_lane, SHIFT);
		item_d.idac_lane = adpdc_pkg::div_step(in_item.idac_lane, SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_q <= item_d;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample rate and word length requests into the clock setup
// calculator and checks every result against a built-in predictor, across
// directed corner cases and random traffic with varying idle and stall rates.
// ----------------------------------------------------------------------------
module testbench;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// sample_rate[18:0], bits_per_sample[24:19]
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// status[1:0] .. mclk_multiple_384[68]
	logic [71:0] m_tdata;

	logic [71:0] setup_q[$];
	int          errors;
	int          send_idle_pct;
	int          recv_stall_pct;

	audio_dac_pll_divider_calc i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predicted packed setup word for one request
	function automatic logic [71:0] clock_setup(logic [18:0] rate, logic [5:0] bits);
		logic [71:0] w;
		logic [1:0]  code;
		logic [31:0] bclk, p, j, nmac, dosr, idac, r, t;
		logic [1:0]  speed;
		w = '0;
		r = {13'd0, rate};
		if (bits == 6'd16) code = adpdc_pkg::WC_16;
		else if (bits == 6'd24) code = adpdc_pkg::WC_24;
		else if (bits == 6'd32) code = adpdc_pkg::WC_32;
		else begin
			w[1:0] = adpdc_pkg::ST_WORD_LEN;
			return w;
		end
		w[68] = (bits == 6'd24);
		bclk = r * {26'd0, bits} * 32'd2;
		if (bclk < 32'd1000000 || bclk > 32'd50000000) begin
			w[1:0] = adpdc_pkg::ST_BCLK;
			return w;
		end
		if ((r == 32'd44100 || r == 32'd48000) && bits == 6'd24) begin
			w[1:0] = adpdc_pkg::ST_RATE24;
			return w;
		end
		if (r == 32'd11025 || r == 32'd22050 || r == 32'd44100) begin
			p = 32'd1; j = 32'd90316800 / bclk / 32'd2; nmac = 32'd2;
			dosr = 32'd8; idac = 32'd1024;
		end else begin
			if (bits == 6'd24 && bclk > 32'd1536000) p = 32'd3;
			else if (bclk > 32'd12288000) p = 32'd2;
			else p = 32'd1;
			j = 32'd98304000 / (bclk / p) / 32'd2;
			if (r == 32'd16000) nmac = 32'd6;
			else if (r == 32'd32000) nmac = 32'd3;
			else nmac = 32'd2;
			dosr = 32'd384000 / r;
			idac = 32'd98304000 / nmac / r;
		end
		if (r <= 32'd48000) speed = 2'd0;
		else if (r <= 32'd96000) speed = 2'd1;
		else if (r <= 32'd192000) speed = 2'd2;
		else speed = 2'd3;
		w[1:0]   = adpdc_pkg::ST_OK;
		t        = p - 32'd1;
		w[3:2]   = t[1:0];
		w[11:4]  = j[7:0];
		w[15:12] = 4'd1;
		t        = nmac - 32'd1;
		w[22:16] = t[6:0];
		w[29:23] = 7'd15;
		w[36:30] = 7'd3;
		t        = dosr - 32'd1;
		w[43:37] = t[6:0];
		w[59:44] = idac[15:0];
		w[61:60] = speed;
		w[67:62] = adpdc_pkg::IFACE_BASE | {4'd0, code};
		return w;
	endfunction

	// send one request and queue its prediction
	task automatic send_request(logic [18:0] rate, logic [5:0] bits);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, bits, rate};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		setup_q.push_back(clock_setup(rate, bits));
		@(negedge clk);
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	// result check
	always @(posedge clk) begin
		logic [71:0] exp_w;
		if (arst_n && m_tvalid && m_tready) begin
			if (setup_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				errors++;
			end else begin
				exp_w = setup_q.pop_front();
				if (m_tdata[68:0] !== exp_w[68:0]) begin
					$display("%0t: mismatch expected %h actual %h", $time, exp_w, m_tdata);
					errors++;
				end
			end
		end
	end

	// sender goes idle until every queued result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (setup_q.size() != 0) @(negedge clk);
	endtask

	task automatic test_directed();
		int unsigned rates[] = '{8000, 11025, 16000, 22050, 32000, 44100, 48000,
			96000, 192000, 384000, 524287, 0};
		foreach (rates[i]) begin
			send_request(19'(rates[i]), 6'd16);
			send_request(19'(rates[i]), 6'd24);
			send_request(19'(rates[i]), 6'd32);
		end
		send_request(19'h7FFFF, 6'h3F);
		send_request(19'd48000, 6'd0);
		send_request(19'd400000, 6'd16);
		send_request(19'(1000000 / 32), 6'd16);
		send_request(19'(50000000 / 64), 6'd32);
	endtask

	task automatic random_phase(int n);
		int unsigned rate, bits;
		int unsigned fam[] = '{8000, 11025, 16000, 22050, 32000, 44100, 48000,
			88200, 96000, 176400, 192000, 384000};
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: rate = fam[$urandom_range(fam.size() - 1)];
				5, 6, 7: rate = $urandom_range(400000, 8000);
				default: rate = $urandom_range(19'h7FFFF);
			endcase
			case ($urandom_range(9))
				0, 1, 2: bits = 16;
				3, 4, 5: bits = 24;
				6, 7, 8: bits = 32;
				default: bits = $urandom_range(63);
			endcase
			send_request(19'(rate), 6'(bits));
		end
	endtask

	task automatic test_random();
		send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(400);
		send_idle_pct = 47; recv_stall_pct = 0;  random_phase(400);
		wait_drained();
		send_idle_pct = 0;  recv_stall_pct = 47; random_phase(400);
		send_idle_pct = 31; recv_stall_pct = 31; random_phase(400);
	endtask

	initial begin
		errors = 0; send_idle_pct = 0; recv_stall_pct = 0;
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0) $display("testbench: PASS");
		else $display("testbench: FAIL");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

### sim.f
hw/rtl/adpdc_pkg.sv
hw/rtl/adpdc_front.sv
hw/rtl/adpdc_div_cell.sv
hw/rtl/audio_dac_pll_divider_calc.sv
tb/testbench.sv
